@@ hdl/pidbc_pkg.sv @@
package pidbc_pkg;

  localparam int unsigned STEP_W = 4;
  localparam int unsigned ACC_W  = 52;
  localparam int unsigned INT_W  = 48;
  localparam int unsigned CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_KP         = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KI_TC      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KD_DIV_TC  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KB         = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_OUT_MAX    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_OUT_MIN    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_OUT_OFFSET = 3'd6;

  typedef enum logic [3:0] {
    ALU_NOP,
    ALU_ERR,
    ALU_NEWI,
    ALU_ACC_P,
    ALU_DIFF,
    ALU_ADD_I,
    ALU_ADD_PROD,
    ALU_CLAMP,
    ALU_GAP,
    ALU_BGAP,
    ALU_INTEG,
    ALU_PREV,
    ALU_EMIT
  } alu_op_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_KI_PREV,
    MUL_KP_ERR,
    MUL_KD_TMP,
    MUL_KB_TMP,
    MUL_TMP_KI
  } mul_sel_t;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_WAIT_IN,
    SEQ_WAIT_OUT
  } seq_cond_t;

  typedef struct packed {
    alu_op_t           alu;
    mul_sel_t          mul;
    seq_cond_t         cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;

  // Control store: one word per step of the program.
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t c;
    c = '{alu: ALU_NOP, mul: MUL_NONE, cond: SEQ_NEXT, target: STEP_IDLE};
    unique case (step)
      4'd0:  c.cond = SEQ_WAIT_IN;
      4'd1:  begin c.alu = ALU_ERR; c.mul = MUL_KI_PREV; end
      4'd2:  begin c.alu = ALU_NEWI; c.mul = MUL_KP_ERR; end
      4'd3:  c.alu = ALU_ACC_P;
      4'd4:  c.alu = ALU_DIFF;
      4'd5:  begin c.alu = ALU_ADD_I; c.mul = MUL_KD_TMP; end
      4'd6:  c.alu = ALU_ADD_PROD;
      4'd7:  c.alu = ALU_CLAMP;
      4'd8:  c.alu = ALU_GAP;
      4'd9:  c.mul = MUL_KB_TMP;
      4'd10: c.alu = ALU_BGAP;
      4'd11: c.mul = MUL_TMP_KI;
      4'd12: c.alu = ALU_INTEG;
      4'd13: c.alu = ALU_PREV;
      4'd14: begin c.alu = ALU_EMIT; c.cond = SEQ_WAIT_OUT; c.target = STEP_IDLE; end
      default: begin c.cond = SEQ_WAIT_OUT; c.target = STEP_IDLE; end
    endcase
    return c;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
    logic signed [31:0] r;
    if (x > $signed({{(ACC_W-31){1'b0}}, {31{1'b1}}})) begin
      r = 32'sh7fffffff;
    end else if (x < $signed({{(ACC_W-31){1'b1}}, {31{1'b0}}})) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [INT_W-1:0] sat48(input logic signed [ACC_W-1:0] x);
    logic signed [INT_W-1:0] r;
    if (x > $signed({{(ACC_W-INT_W+1){1'b0}}, {(INT_W-1){1'b1}}})) begin
      r = {1'b0, {(INT_W-1){1'b1}}};
    end else if (x < $signed({{(ACC_W-INT_W+1){1'b1}}, {(INT_W-1){1'b0}}})) begin
      r = {1'b1, {(INT_W-1){1'b0}}};
    end else begin
      r = x[INT_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ hdl/pid_back_calc_antiwindup_unit.sv @@
// Discrete PID controller step in Q16.16 with back-calculation anti-windup.
// Each input transfer (measured, reference, clear) yields exactly one output
// transfer (drive, limited). A small microcoded sequencer steps one shared
// 32 x 32 multiplier and one adder/saturator through the calculation: an item
// passes through one accept step and fourteen program steps, a number set by
// the five multiplications that share the multiplier. The result sits in an
// output register, so the next item is accepted while it waits; the final step
// waits only if the previous result has not yet been taken. The user must write
// registers through the configuration channel while the block is idle; the
// block does not enforce this. An index beyond the register list is ignored.
module pid_back_calc_antiwindup_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [pidbc_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [31:0]                            cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [31:0]                     measured,
  input  logic signed [31:0]                     reference,
  input  logic                                   clear,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [31:0]                     drive,
  output logic                                   limited
);

  logic signed [31:0] kp, ki_tc, kd_div_tc, kb, out_max, out_min, out_offset;

  logic [pidbc_pkg::STEP_W-1:0]             step, step_next;
  pidbc_pkg::ctrl_t                         ctrl;

  logic signed [31:0]                       y_in, r_in;
  logic signed [31:0]                       err, prev_error, tmp, satu;
  logic                                     lim;
  logic signed [pidbc_pkg::INT_W-1:0]       integrator, newi;
  logic signed [pidbc_pkg::ACC_W-1:0]       acc;
  logic signed [63:0]                       prod;
  logic signed [31:0]                       mul_a, mul_b;
  logic signed [pidbc_pkg::ACC_W-1:0]       prod_q;

  logic in_accept, out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = (step == pidbc_pkg::STEP_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign ctrl      = pidbc_pkg::ucode(step);

  // The product shifted right by 16 is a floor; bits above 47 are sign only.
  assign prod_q = {{(pidbc_pkg::ACC_W-48){prod[63]}}, prod[63:16]};

  always_ff @(posedge clk) begin
    if (rst) begin
      kp         <= '0;
      ki_tc      <= '0;
      kd_div_tc  <= '0;
      kb         <= '0;
      out_max    <= 32'sh7fffffff;
      out_min    <= 32'sh80000000;
      out_offset <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pidbc_pkg::REG_KP:         kp         <= cfg_data;
        pidbc_pkg::REG_KI_TC:      ki_tc      <= cfg_data;
        pidbc_pkg::REG_KD_DIV_TC:  kd_div_tc  <= cfg_data;
        pidbc_pkg::REG_KB:         kb         <= cfg_data;
        pidbc_pkg::REG_OUT_MAX:    out_max    <= cfg_data;
        pidbc_pkg::REG_OUT_MIN:    out_min    <= cfg_data;
        pidbc_pkg::REG_OUT_OFFSET: out_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    step_next = step + 1'b1;
    unique case (ctrl.cond)
      pidbc_pkg::SEQ_NEXT:     step_next = step + 1'b1;
      pidbc_pkg::SEQ_WAIT_IN:  step_next = in_accept ? step + 1'b1 : step;
      pidbc_pkg::SEQ_WAIT_OUT: step_next = out_free ? ctrl.target : step;
      default:                 step_next = pidbc_pkg::STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= pidbc_pkg::STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.mul)
      pidbc_pkg::MUL_KI_PREV: begin mul_a = ki_tc;     mul_b = prev_error; end
      pidbc_pkg::MUL_KP_ERR:  begin mul_a = kp;        mul_b = err;        end
      pidbc_pkg::MUL_KD_TMP:  begin mul_a = kd_div_tc; mul_b = tmp;        end
      pidbc_pkg::MUL_KB_TMP:  begin mul_a = kb;        mul_b = tmp;        end
      pidbc_pkg::MUL_TMP_KI:  begin mul_a = tmp;       mul_b = ki_tc;      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul != pidbc_pkg::MUL_NONE) begin
      prod <= mul_a * mul_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integrator <= '0;
      prev_error <= '0;
    end else if (in_accept) begin
      if (clear) begin
        integrator <= '0;
        prev_error <= '0;
      end
    end else begin
      case (ctrl.alu)
        pidbc_pkg::ALU_INTEG:
          integrator <= pidbc_pkg::sat48(
            {{(pidbc_pkg::ACC_W-pidbc_pkg::INT_W){newi[pidbc_pkg::INT_W-1]}}, newi} + prod_q);
        pidbc_pkg::ALU_PREV:
          prev_error <= err;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      y_in <= measured;
      r_in <= reference;
    end
    case (ctrl.alu)
      pidbc_pkg::ALU_ERR:
        err <= pidbc_pkg::sat32(
          {{(pidbc_pkg::ACC_W-32){r_in[31]}}, r_in} - {{(pidbc_pkg::ACC_W-32){y_in[31]}}, y_in});
      pidbc_pkg::ALU_NEWI:
        newi <= pidbc_pkg::sat48(
          {{(pidbc_pkg::ACC_W-pidbc_pkg::INT_W){integrator[pidbc_pkg::INT_W-1]}}, integrator}
          + prod_q);
      pidbc_pkg::ALU_ACC_P:
        acc <= prod_q + {{(pidbc_pkg::ACC_W-32){out_offset[31]}}, out_offset};
      pidbc_pkg::ALU_DIFF:
        tmp <= pidbc_pkg::sat32(
          {{(pidbc_pkg::ACC_W-32){err[31]}}, err}
          - {{(pidbc_pkg::ACC_W-32){prev_error[31]}}, prev_error});
      pidbc_pkg::ALU_ADD_I:
        acc <= acc + {{(pidbc_pkg::ACC_W-pidbc_pkg::INT_W){newi[pidbc_pkg::INT_W-1]}}, newi};
      pidbc_pkg::ALU_ADD_PROD:
        acc <= acc + prod_q;
      pidbc_pkg::ALU_CLAMP: begin
        // The upper limit is tested first, which settles crossed limits.
        if (acc > $signed({{(pidbc_pkg::ACC_W-32){out_max[31]}}, out_max})) begin
          satu <= out_max;
          lim  <= 1'b1;
        end else if (acc < $signed({{(pidbc_pkg::ACC_W-32){out_min[31]}}, out_min})) begin
          satu <= out_min;
          lim  <= 1'b1;
        end else begin
          satu <= acc[31:0];
          lim  <= 1'b0;
        end
      end
      pidbc_pkg::ALU_GAP:
        tmp <= pidbc_pkg::sat32({{(pidbc_pkg::ACC_W-32){satu[31]}}, satu} - acc);
      pidbc_pkg::ALU_BGAP:
        tmp <= pidbc_pkg::sat32(prod_q);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.alu == pidbc_pkg::ALU_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.alu == pidbc_pkg::ALU_EMIT && out_free) begin
      drive   <= satu;
      limited <= lim;
    end
  end

endmodule
